FILE: hw/rtl/grid_box_decode_argmax_macros.svh
// assertion macros for the box decode block
`ifndef GRID_BOX_DECODE_ARGMAX_MACROS_SVH
`define GRID_BOX_DECODE_ARGMAX_MACROS_SVH

// same-cycle implication
`define GBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gbd_pkg.sv
`timescale 1ns / 1ps
package gbd_pkg;

  localparam int LOGIT_W = 16;
  localparam int FRAC_W  = 8;
  localparam int CLASS_W = 7;
  localparam int CELL_W  = 7;
  localparam int LEVEL_W = 2;
  localparam int BOX_W   = 18;
  localparam int SCORE_W = 8;
  localparam int DIST_W  = LOGIT_W + 3;

  localparam int CLASS_COUNT = 80;
  localparam int GRID_MAX    = 128;
  localparam int BOX_MAX     = 131071;
  localparam int BOX_MIN     = -131072;
  localparam int SCORE_BIAS  = 128;
  localparam int SCORE_MAX   = 255;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [LOGIT_W-1:0] logit_t;
  typedef logic [CLASS_W-1:0]        class_t;
  typedef logic [CELL_W-1:0]         cell_t;
  typedef logic [LEVEL_W-1:0]        level_t;
  typedef logic signed [BOX_W-1:0]   box_t;
  typedef logic [SCORE_W-1:0]        score_t;

  localparam level_t LEVEL_S8  = 2'd0;
  localparam level_t LEVEL_S16 = 2'd1;

  localparam logit_t THRESH_RESET = -16'sd281;

  // closed cell that passed the threshold
  typedef struct packed {
    logit_t best_logit;
    class_t best_index;
    cell_t  cell_x;
    cell_t  cell_y;
    level_t level;
    logit_t dist_left;
    logit_t dist_top;
    logit_t dist_right;
    logit_t dist_bottom;
  } close_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [255:0][SCORE_W-1:0] sig_tab_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // sigmoid by euler steps in q30, evaluated at elaboration
  function automatic sig_tab_t build_sig();
    sig_tab_t    tab;
    logic [63:0] s;
    logic [63:0] v;
    int          steps;
    tab = '0;
    s   = Q30_ONE >> 1;
    for (int k = 0; k < 128; k++) begin
      steps = (k == 0) ? 32 : 64;
      for (int n = 0; n < steps; n++) begin
        s = s + ((s * (Q30_ONE - s)) >> 40);
      end
      v = (64'd255 * s + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd255) begin
        v = 64'd255;
      end
      tab[128 + k] = v[7:0];
      tab[127 - k] = 8'd255 - v[7:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig();

endpackage

FILE: hw/rtl/gbd_if.sv
`timescale 1ns / 1ps
interface gbd_item_if ();
  import gbd_pkg::*;
  logic   valid;
  logic   ready;
  logit_t class_logit;
  logic   last_class;
  cell_t  cell_x;
  cell_t  cell_y;
  level_t level;
  logit_t dist_left;
  logit_t dist_top;
  logit_t dist_right;
  logit_t dist_bottom;
  modport source (output valid, class_logit, last_class, cell_x, cell_y, level,
                  dist_left, dist_top, dist_right, dist_bottom, input ready);
  modport sink (input valid, class_logit, last_class, cell_x, cell_y, level,
                dist_left, dist_top, dist_right, dist_bottom, output ready);
endinterface

interface gbd_result_if ();
  import gbd_pkg::*;
  logic   valid;
  logic   ready;
  box_t   box_left;
  box_t   box_top;
  box_t   box_right;
  box_t   box_bottom;
  class_t class_idx;
  score_t score;
  modport source (output valid, box_left, box_top, box_right, box_bottom, class_idx,
                  score, input ready);
  modport sink (input valid, box_left, box_top, box_right, box_bottom, class_idx,
                score, output ready);
endinterface

interface gbd_cfg_if ();
  import gbd_pkg::*;
  logic   valid;
  logic   ready;
  logit_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/gbd_queue.sv
`timescale 1ns / 1ps
module gbd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  gbd_pkg::close_t   push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output gbd_pkg::close_t   pop_data,
  output gbd_pkg::q_stat_t  stat
);
  import gbd_pkg::*;

  close_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop_fire) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/gbd_front.sv
`timescale 1ns / 1ps
module gbd_front (
  input  logic             clk,
  input  logic             rst,
  gbd_item_if.sink         items,
  input  gbd_pkg::logit_t  threshold,
  output logic             push_valid,
  input  logic             push_ready,
  output gbd_pkg::close_t  push_data
);
  import gbd_pkg::*;

  logit_t best_logit;
  class_t best_index;
  class_t class_counter;
  logit_t best_logit_next;
  class_t best_index_next;
  logic   take;
  logic   accept;

  assign items.ready = push_ready;
  assign accept      = items.valid && items.ready;

  always_comb begin
    take = (class_counter == '0) ||
           (({1'b0, class_counter} < (CLASS_W + 1)'(CLASS_COUNT)) &&
            (items.class_logit > best_logit));
    best_logit_next = take ? items.class_logit : best_logit;
    best_index_next = take ? class_counter : best_index;
  end

  assign push_valid = items.valid && items.last_class && (best_logit_next >= threshold);

  always_comb begin
    push_data.best_logit  = best_logit_next;
    push_data.best_index  = best_index_next;
    push_data.cell_x      = items.cell_x;
    push_data.cell_y      = items.cell_y;
    push_data.level       = items.level;
    push_data.dist_left   = items.dist_left;
    push_data.dist_top    = items.dist_top;
    push_data.dist_right  = items.dist_right;
    push_data.dist_bottom = items.dist_bottom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_logit    <= '0;
      best_index    <= '0;
      class_counter <= '0;
    end else if (accept) begin
      if (items.last_class) begin
        best_logit    <= '0;
        best_index    <= '0;
        class_counter <= '0;
      end else begin
        best_logit <= best_logit_next;
        best_index <= best_index_next;
        if (class_counter != '1) begin
          class_counter <= class_counter + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/gbd_back.sv
`timescale 1ns / 1ps
module gbd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  gbd_pkg::close_t  pop_data,
  gbd_result_if.source     results
);
  import gbd_pkg::*;

  typedef logic signed [DIST_W-1:0] dist_t;

  logic   out_valid;
  box_t   box_left;
  box_t   box_top;
  box_t   box_right;
  box_t   box_bottom;
  class_t class_idx;
  score_t score;

  box_t   left_next;
  box_t   top_next;
  box_t   right_next;
  box_t   bottom_next;
  score_t score_next;
  cell_t  cx;
  cell_t  cy;
  dist_t  ctr_x;
  dist_t  ctr_y;
  logic signed [LOGIT_W-5:0] logit_hi;
  logic signed [LOGIT_W-4:0] sidx;
  logic   pop_fire;

  function automatic cell_t clamp_cell(input cell_t c);
    return ({1'b0, c} >= (CELL_W + 1)'(GRID_MAX)) ? CELL_W'(GRID_MAX - 1) : c;
  endfunction

  // d * stride / 16, floored, then saturated
  function automatic box_t edge_q4(input dist_t d, input level_t lvl);
    logic signed [DIST_W:0] x;
    x = (DIST_W + 1)'(d);
    unique case (lvl)
      LEVEL_S8:  x = x >>> 1;
      LEVEL_S16: x = x;
      default:   x = x <<< 1;
    endcase
    if (x > (DIST_W + 1)'(BOX_MAX)) begin
      return BOX_W'(BOX_MAX);
    end else if (x < (DIST_W + 1)'(BOX_MIN)) begin
      return BOX_W'(BOX_MIN);
    end
    return BOX_W'(x);
  endfunction

  assign pop_ready = !out_valid || results.ready;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    cx    = clamp_cell(pop_data.cell_x);
    cy    = clamp_cell(pop_data.cell_y);
    ctr_x = $signed({{(DIST_W - CELL_W - FRAC_W){1'b0}}, cx, 1'b1, {(FRAC_W - 1){1'b0}}});
    ctr_y = $signed({{(DIST_W - CELL_W - FRAC_W){1'b0}}, cy, 1'b1, {(FRAC_W - 1){1'b0}}});
    left_next   = edge_q4(ctr_x - DIST_W'(pop_data.dist_left), pop_data.level);
    top_next    = edge_q4(ctr_y - DIST_W'(pop_data.dist_top), pop_data.level);
    right_next  = edge_q4(ctr_x + DIST_W'(pop_data.dist_right), pop_data.level);
    bottom_next = edge_q4(ctr_y + DIST_W'(pop_data.dist_bottom), pop_data.level);
    logit_hi = $signed(pop_data.best_logit[LOGIT_W-1:4]);
    sidx     = (LOGIT_W - 3)'(logit_hi) + (LOGIT_W - 3)'(SCORE_BIAS);
    if (sidx < 0) begin
      score_next = SIG_TABLE[0];
    end else if (sidx > (LOGIT_W - 3)'(SCORE_MAX)) begin
      score_next = SIG_TABLE[SCORE_MAX];
    end else begin
      score_next = SIG_TABLE[sidx[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      box_left   <= left_next;
      box_top    <= top_next;
      box_right  <= right_next;
      box_bottom <= bottom_next;
      class_idx  <= pop_data.best_index;
      score      <= score_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid      = out_valid;
  assign results.box_left   = box_left;
  assign results.box_top    = box_top;
  assign results.box_right  = box_right;
  assign results.box_bottom = box_bottom;
  assign results.class_idx  = class_idx;
  assign results.score      = score;

endmodule

FILE: hw/rtl/grid_box_decode_argmax.sv
// one class word per cycle while the queue has room; argmax compare is a combinational step in the front
// a passing cell is written into the queue with its last word, then popped into the output register
// a two-cell queue and the output register decouple input and output stalls
// reset clears the argmax state, the queue, the output valid
// and loads the threshold with -281 (sigmoid 0.25)
`timescale 1ns / 1ps
`include "grid_box_decode_argmax_macros.svh"
module grid_box_decode_argmax (
  input  logic         clk,
  input  logic         rst,
  gbd_item_if.sink     items,
  gbd_result_if.source results,
  gbd_cfg_if.sink      cfg
);
  import gbd_pkg::*;

  logit_t  threshold;
  logic    push_valid;
  logic    push_ready;
  close_t  push_data;
  logic    pop_valid;
  logic    pop_ready;
  close_t  pop_data;
  q_stat_t q_stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      threshold <= cfg.data;
    end
  end

  gbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .threshold  (threshold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .stat       (q_stat)
  );

  gbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

  `GBD_ASSERT_NOW(a_queue_state, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  `GBD_ASSERT_NEXT(a_drain, !q_stat.empty && !results.valid, results.valid, "queued word stuck")
  `GBD_ASSERT_NOW(a_reset_clear, $past(rst), !results.valid, "result valid out of reset")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import gbd_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 72;
  localparam int BURST_WORDS   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logit_t THR_AT_RESET = -16'sd281;
  localparam logit_t LOGIT_MIN    = 16'sh8000;
  localparam logit_t LOGIT_MAX    = 16'sh7fff;

  typedef struct {
    logit_t logit;
    logic   last;
    cell_t  cx;
    cell_t  cy;
    level_t level;
    logit_t dl;
    logit_t dt;
    logit_t dr;
    logit_t db;
  } class_word_t;

  typedef struct {
    box_t   left;
    box_t   top;
    box_t   right;
    box_t   bottom;
    class_t id;
    score_t score;
  } box_rec_t;

  class cell_box_tracker;
    score_t   sig_lut[256];
    logit_t   thr;
    logit_t   best;
    class_t   best_id;
    class_t   seen;
    box_rec_t boxes_due[$];
    int       mismatches;

    function new();
      longint unsigned s;
      longint unsigned v;
      int steps;
      s = 64'd1 << 29;
      for (int k = 0; k < 128; k++) begin
        steps = (k == 0) ? 32 : 64;
        for (int n = 0; n < steps; n++) begin
          s = s + ((s * ((64'd1 << 30) - s)) >> 40);
        end
        v = (64'd255 * s + (64'd1 << 29)) >> 30;
        if (v > 64'd255) begin
          v = 64'd255;
        end
        sig_lut[128 + k] = v[7:0];
        sig_lut[127 - k] = 8'd255 - v[7:0];
      end
      thr        = THR_AT_RESET;
      best       = '0;
      best_id    = '0;
      seen       = '0;
      mismatches = 0;
    endfunction

    function void set_threshold(logit_t v);
      thr = v;
    endfunction

    // floor of d * stride / 16, clamped to the box range
    function box_t edge_px(int d, int stride);
      longint p;
      p = (longint'(d) * stride) >>> 4;
      if (p > BOX_MAX) begin
        p = BOX_MAX;
      end
      if (p < BOX_MIN) begin
        p = BOX_MIN;
      end
      return box_t'(p);
    endfunction

    function void take_word(class_word_t w);
      int stride;
      int ccx;
      int ccy;
      int idx;
      box_rec_t b;
      if (seen == 0) begin
        best    = w.logit;
        best_id = '0;
      end else if (seen < CLASS_COUNT && w.logit > best) begin
        best    = w.logit;
        best_id = seen;
      end
      if (!w.last) begin
        if (seen != 7'd127) begin
          seen++;
        end
        return;
      end
      if (best >= thr) begin
        stride = 8 << ((w.level > 2) ? 2 : int'(w.level));
        ccx = (w.cx >= GRID_MAX) ? GRID_MAX - 1 : int'(w.cx);
        ccy = (w.cy >= GRID_MAX) ? GRID_MAX - 1 : int'(w.cy);
        ccx = ccx * 256 + 128;
        ccy = ccy * 256 + 128;
        b.left   = edge_px(ccx - int'(w.dl), stride);
        b.top    = edge_px(ccy - int'(w.dt), stride);
        b.right  = edge_px(ccx + int'(w.dr), stride);
        b.bottom = edge_px(ccy + int'(w.db), stride);
        b.id     = best_id;
        idx = (int'(best) >>> 4) + 128;
        if (idx < 0) begin
          idx = 0;
        end
        if (idx > 255) begin
          idx = 255;
        end
        b.score = sig_lut[idx];
        boxes_due.insert(boxes_due.size(), b);
      end
      best    = '0;
      best_id = '0;
      seen    = '0;
    endfunction

    function void cmp_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_box(box_rec_t got);
      box_rec_t want;
      if (boxes_due.size() == 0) begin
        $error("box with no cell pending: box_left %0d class_idx %0d", got.left, got.id);
        mismatches++;
        return;
      end
      want = boxes_due.pop_front();
      cmp_field("box_left", want.left, got.left);
      cmp_field("box_top", want.top, got.top);
      cmp_field("box_right", want.right, got.right);
      cmp_field("box_bottom", want.bottom, got.bottom);
      cmp_field("class_idx", want.id, got.id);
      cmp_field("score", want.score, got.score);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  gbd_item_if   items_if ();
  gbd_result_if res_if ();
  gbd_cfg_if    cfg_if ();

  grid_box_decode_argmax u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  cell_box_tracker tracker;
  logit_t cur_thr   = THR_AT_RESET;
  int     src_idle  = 0;
  int     snk_stall = 0;
  int     hold_seq  = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls plus long holds on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin : watch
    box_rec_t    got;
    class_word_t w;
    if (!rst) begin
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.left   = res_if.box_left;
        got.top    = res_if.box_top;
        got.right  = res_if.box_right;
        got.bottom = res_if.box_bottom;
        got.id     = res_if.class_idx;
        got.score  = res_if.score;
        tracker.check_box(got);
      end
      if (items_if.valid === 1'b1 && items_if.ready === 1'b1) begin
        w.logit = items_if.class_logit;
        w.last  = items_if.last_class;
        w.cx    = items_if.cell_x;
        w.cy    = items_if.cell_y;
        w.level = items_if.level;
        w.dl    = items_if.dist_left;
        w.dt    = items_if.dist_top;
        w.dr    = items_if.dist_right;
        w.db    = items_if.dist_bottom;
        tracker.take_word(w);
      end
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
        tracker.set_threshold(cfg_if.data);
      end
    end
  end

  function automatic class_word_t mk_word(logit_t logit, logic last, cell_t cx, cell_t cy,
                                          level_t level, logit_t dl, logit_t dt,
                                          logit_t dr, logit_t db);
    class_word_t w;
    w.logit = logit;
    w.last  = last;
    w.cx    = cx;
    w.cy    = cy;
    w.level = level;
    w.dl    = dl;
    w.dt    = dt;
    w.dr    = dr;
    w.db    = db;
    return w;
  endfunction

  function automatic logit_t rand_logit();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return logit_t'($urandom);
    end
    if (pick < 50) begin
      // around the current threshold
      v = int'(cur_thr) + int'($urandom_range(6)) - 3;
      if (v < -32768) begin
        v = -32768;
      end
      if (v > 32767) begin
        v = 32767;
      end
      return logit_t'(v);
    end
    if (pick < 65) begin
      // few distinct values so ties happen
      return logit_t'(int'($urandom_range(2)) * 100 - 100);
    end
    if (pick < 75) begin
      return $urandom_range(1) ? LOGIT_MAX : LOGIT_MIN;
    end
    return logit_t'(int'($urandom_range(4096)) - 2048);
  endfunction

  function automatic logit_t rand_dist();
    if ($urandom_range(1)) begin
      return logit_t'($urandom);
    end
    return logit_t'(int'($urandom_range(4096)) - 2048);
  endfunction

  function automatic class_word_t rand_word(logic last);
    return mk_word(rand_logit(), last, cell_t'($urandom_range(127)),
                   cell_t'($urandom_range(127)), level_t'($urandom_range(3)),
                   rand_dist(), rand_dist(), rand_dist(), rand_dist());
  endfunction

  function automatic int cell_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      return $urandom_range(6, 1);
    end
    if (pick < 94) begin
      return $urandom_range(40, 7);
    end
    if (pick < 99) begin
      return $urandom_range(90, 78);
    end
    return $urandom_range(135, 125);
  endfunction

  task automatic send_item(input class_word_t w);
    while (src_idle != 0 && $urandom_range(99) < src_idle) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid       <= 1'b1;
    items_if.class_logit <= w.logit;
    items_if.last_class  <= w.last;
    items_if.cell_x      <= w.cx;
    items_if.cell_y      <= w.cy;
    items_if.level       <= w.level;
    items_if.dist_left   <= w.dl;
    items_if.dist_top    <= w.dt;
    items_if.dist_right  <= w.dr;
    items_if.dist_bottom <= w.db;
    @(posedge clk);
    while (items_if.ready !== 1'b1) begin
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    items_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.boxes_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_threshold(input logit_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    cur_thr = v;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) begin
      @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_cells(input int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = cell_len();
      for (int i = 0; i < len; i++) begin
        send_item(rand_word(i == len - 1));
      end
      sent += len;
    end
  endtask

  initial begin
    logit_t thr_plan[PHASES];
    int     saved_idle;
    tracker = new();
    rst                  = 1'b1;
    items_if.valid       = 1'b0;
    items_if.class_logit = '0;
    items_if.last_class  = 1'b0;
    items_if.cell_x      = '0;
    items_if.cell_y      = '0;
    items_if.level       = '0;
    items_if.dist_left   = '0;
    items_if.dist_top    = '0;
    items_if.dist_right  = '0;
    items_if.dist_bottom = '0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.data          = '0;
    thr_plan[0] = THR_AT_RESET;
    thr_plan[1] = LOGIT_MIN;
    thr_plan[2] = 16'sd512;
    thr_plan[3] = LOGIT_MAX;
    thr_plan[4] = logit_t'($urandom);
    thr_plan[5] = -16'sd1024;
    thr_plan[6] = logit_t'($urandom);
    thr_plan[7] = 16'sd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed cells at the reset threshold
    send_item(mk_word(LOGIT_MAX, 1'b1, 7'd127, 7'd127, 2'd3,
                      LOGIT_MIN, LOGIT_MIN, LOGIT_MAX, LOGIT_MAX));
    send_item(mk_word(LOGIT_MIN, 1'b1, 7'd0, 7'd0, LEVEL_S8,
                      LOGIT_MAX, LOGIT_MAX, LOGIT_MIN, LOGIT_MIN));
    send_item(mk_word(-16'sd281, 1'b1, 7'd0, 7'd127, LEVEL_S16,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(-16'sd282, 1'b1, 7'd127, 7'd0, 2'd2,
                      16'sd256, 16'sd256, 16'sd256, 16'sd256));
    send_item(mk_word(16'sd100, 1'b0, 7'd85, 7'd42, 2'd3,
                      LOGIT_MAX, LOGIT_MIN, LOGIT_MAX, LOGIT_MIN));
    send_item(mk_word(16'sd100, 1'b1, 7'd42, 7'd85, 2'd2,
                      -16'sd1, -16'sd1, -16'sd1, -16'sd1));
    send_item(mk_word(16'sd5, 1'b0, 7'd0, 7'd0, LEVEL_S8,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(16'sd200, 1'b0, 7'd127, 7'd127, 2'd3,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(16'sd200, 1'b0, 7'd1, 7'd1, LEVEL_S16,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(16'sd7, 1'b1, 7'd64, 7'd63, 2'd3,
                      16'sd384, 16'sd640, 16'sd896, 16'sd1152));
    send_item(mk_word(LOGIT_MIN, 1'b0, 7'd3, 7'd4, LEVEL_S8,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(LOGIT_MIN, 1'b0, 7'd5, 7'd6, LEVEL_S16,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(LOGIT_MAX, 1'b1, 7'd10, 7'd20, LEVEL_S16,
                      LOGIT_MIN, LOGIT_MAX, LOGIT_MIN, LOGIT_MAX));
    send_item(mk_word(-16'sd1000, 1'b0, 7'd0, 7'd0, LEVEL_S8,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(-16'sd2000, 1'b1, 7'd0, 7'd0, LEVEL_S8,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(-16'sd100, 1'b0, 7'd0, 7'd0, LEVEL_S8,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(mk_word(-16'sd2000, 1'b1, 7'd127, 7'd0, 2'd3,
                      16'sd128, 16'sd128, 16'sd128, 16'sd128));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_threshold(thr_plan[p]);
      case (p % 4)
        0: begin
          src_idle = 0;
          snk_stall <= 0;
        end
        1: begin
          src_idle = 59;
          snk_stall <= 0;
        end
        2: begin
          src_idle = 0;
          snk_stall <= 59;
        end
        default: begin
          src_idle = 14;
          snk_stall <= 14;
        end
      endcase
      if (p == 1) begin
        // long output hold while single-word cells keep coming
        hold_seq <= hold_seq + 1;
        saved_idle = src_idle;
        src_idle = 0;
        repeat (BURST_WORDS) send_item(rand_word(1'b1));
        src_idle = saved_idle;
      end
      run_cells(PHASE_WORDS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.boxes_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
